@@ hw/rtl/bbr_pkg.sv @@
// ---------------------------------------------------------------------------
// bbr_pkg
// Shared types and constants of the bracket balance repair block.
// ---------------------------------------------------------------------------
package bbr_pkg;

    // default sizes
    localparam int DEF_STACK_DEPTH = 16;
    localparam int DEF_TAG_BITS    = 32;
    localparam int DEF_KIND_BITS   = 2;
    localparam int DEF_QUEUE_DEPTH = 2;

    // input codes
    localparam int  SIDE_BITS  = 2;
    localparam logic [SIDE_BITS-1:0] SIDE_OPEN  = 2'd1;
    localparam logic [SIDE_BITS-1:0] SIDE_CLOSE = 2'd2;
    localparam logic REQ_FLUSH = 1'b1;

    // command from front to back
    localparam int OP_BITS = 2;
    typedef enum logic [OP_BITS-1:0] {
        OP_PASS  = 2'd0,
        OP_OPEN  = 2'd1,
        OP_CLOSE = 2'd2,
        OP_FLUSH = 2'd3
    } t_op;

    // per-result flags
    typedef struct packed {
        logic inserted;
        logic overflow;
        logic last;
    } t_res_flags;

    localparam int FLAG_BITS = $bits(t_res_flags);

endpackage

@@ hw/rtl/bracket_balance_repair.sv @@
// ---------------------------------------------------------------------------
// bracket_balance_repair
// Repairs bracket balance of a token stream with a stack of open kinds.
// ---------------------------------------------------------------------------
//  channel  | handshake         | payload
//  ---------+-------------------+-------------------------------------------
//  input    | push / full       | req_type, token_tag, bracket_side, kind
//  result   | empty / pop       | out_tag, inserted, kind, overflow, last
//
//  Plain tokens, opens and dropped closers are handled in the idle state;
//  closer repair and flush are taken there, then pass a read and an eval
//  state per stack entry popped, set by the registered stack memory read.
//  A command queue and a result queue let input and output stall apart.
//  Synchronous reset empties the stack and both queues; stack memory
//  contents are left as they are.
// ---------------------------------------------------------------------------
module bracket_balance_repair #(
    parameter int STACK_DEPTH = bbr_pkg::DEF_STACK_DEPTH,
    parameter int TAG_BITS    = bbr_pkg::DEF_TAG_BITS,
    parameter int KIND_BITS   = bbr_pkg::DEF_KIND_BITS,
    parameter int QUEUE_DEPTH = bbr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_req_type,
    input  logic [TAG_BITS-1:0]           i_token_tag,
    input  logic [bbr_pkg::SIDE_BITS-1:0] i_bracket_side,
    input  logic [KIND_BITS-1:0]          i_bracket_kind,
    output logic                          empty,
    input  logic                          pop,
    output logic [TAG_BITS-1:0]           o_out_tag,
    output logic                          o_out_inserted,
    output logic [KIND_BITS-1:0]          o_out_bracket_kind,
    output logic                          o_out_overflow,
    output logic                          o_out_last
);

    localparam int CMD_W = bbr_pkg::OP_BITS + TAG_BITS + KIND_BITS;
    localparam int RES_W = TAG_BITS + bbr_pkg::FLAG_BITS + KIND_BITS;

    logic                 cmd_wr, cmd_rd, cmd_empty;
    logic [CMD_W-1:0]     cmd_in, cmd_q;
    bbr_pkg::t_op         cmd_op;
    logic [TAG_BITS-1:0]  cmd_tag;
    logic [KIND_BITS-1:0] cmd_kind;

    logic                 res_wr, res_full;
    logic [TAG_BITS-1:0]  res_tag;
    bbr_pkg::t_res_flags  res_flags, out_flags;
    logic [KIND_BITS-1:0] res_kind;
    logic [RES_W-1:0]     res_q;

    // front: take beats and classify
    bbr_front #(
        .TAG_BITS  (TAG_BITS),
        .KIND_BITS (KIND_BITS),
        .CMD_W     (CMD_W)
    ) u_front (
        .i_push         (push),
        .i_full         (full),
        .i_req_type     (i_req_type),
        .i_token_tag    (i_token_tag),
        .i_bracket_side (i_bracket_side),
        .i_bracket_kind (i_bracket_kind),
        .o_wr           (cmd_wr),
        .o_cmd          (cmd_in)
    );

    // command queue between front and back
    bbr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_wr),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_rd    (cmd_rd),
        .o_data  (cmd_q),
        .o_empty (cmd_empty)
    );

    assign cmd_op   = bbr_pkg::t_op'(cmd_q[CMD_W-1 -: bbr_pkg::OP_BITS]);
    assign cmd_tag  = cmd_q[KIND_BITS +: TAG_BITS];
    assign cmd_kind = cmd_q[KIND_BITS-1:0];

    // back: stack engine
    bbr_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .TAG_BITS    (TAG_BITS),
        .KIND_BITS   (KIND_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd_op    (cmd_op),
        .i_cmd_tag   (cmd_tag),
        .i_cmd_kind  (cmd_kind),
        .o_cmd_rd    (cmd_rd),
        .i_res_full  (res_full),
        .o_res_wr    (res_wr),
        .o_res_tag   (res_tag),
        .o_res_flags (res_flags),
        .o_res_kind  (res_kind)
    );

    // result queue towards the consumer
    bbr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_data  ({res_tag, res_flags, res_kind}),
        .o_full  (res_full),
        .i_rd    (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    // unpack result beat
    assign o_out_tag          = res_q[RES_W-1 -: TAG_BITS];
    assign out_flags          = res_q[KIND_BITS +: bbr_pkg::FLAG_BITS];
    assign o_out_bracket_kind = res_q[KIND_BITS-1:0];
    assign o_out_inserted     = out_flags.inserted;
    assign o_out_overflow     = out_flags.overflow;
    assign o_out_last         = out_flags.last;

`ifndef SYNTH
    // the engine never writes a full result queue
    a_res_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_wr |-> !res_full)
        else $error("result written into full queue");

    // the engine only takes a command that is there
    a_cmd_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_rd |-> !cmd_empty)
        else $error("command read from empty queue");

    // synthesized closers carry no tag and never flag overflow
    a_inserted_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_wr && res_flags.inserted) |-> (res_tag == '0 && !res_flags.overflow))
        else $error("inserted closer with tag or overflow");
`endif

endmodule

@@ hw/rtl/bbr_fifo.sv @@
// ---------------------------------------------------------------------------
// bbr_fifo
// Small register queue with independent write and read sides.
// ---------------------------------------------------------------------------
module bbr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bbr_pkg::DEF_QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             wr_en, rd_en;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    // pointer and fill level update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CW'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ hw/rtl/bbr_front.sv @@
// ---------------------------------------------------------------------------
// bbr_front
// Accepts input beats and classifies them into back-end commands.
// ---------------------------------------------------------------------------
module bbr_front #(
    parameter int TAG_BITS  = bbr_pkg::DEF_TAG_BITS,
    parameter int KIND_BITS = bbr_pkg::DEF_KIND_BITS,
    parameter int CMD_W     = bbr_pkg::OP_BITS + TAG_BITS + KIND_BITS
) (
    input  logic                          i_push,
    input  logic                          i_full,
    input  logic                          i_req_type,
    input  logic [TAG_BITS-1:0]           i_token_tag,
    input  logic [bbr_pkg::SIDE_BITS-1:0] i_bracket_side,
    input  logic [KIND_BITS-1:0]          i_bracket_kind,
    output logic                          o_wr,
    output logic [CMD_W-1:0]              o_cmd
);

    bbr_pkg::t_op op;

    // classify: flush first, then side code; undefined side passes through
    always_comb begin
        if (i_req_type == bbr_pkg::REQ_FLUSH) begin
            op = bbr_pkg::OP_FLUSH;
        end else begin
            case (i_bracket_side)
                bbr_pkg::SIDE_OPEN:  op = bbr_pkg::OP_OPEN;
                bbr_pkg::SIDE_CLOSE: op = bbr_pkg::OP_CLOSE;
                default:             op = bbr_pkg::OP_PASS;
            endcase
        end
    end

    assign o_wr  = i_push && !i_full;
    assign o_cmd = {op, i_token_tag, i_bracket_kind};

endmodule

@@ hw/rtl/bbr_back.sv @@
// ---------------------------------------------------------------------------
// bbr_back
// Bracket stack engine: pushes opens, unwinds closers and flushes.
// ---------------------------------------------------------------------------
module bbr_back #(
    parameter int STACK_DEPTH = bbr_pkg::DEF_STACK_DEPTH,
    parameter int TAG_BITS    = bbr_pkg::DEF_TAG_BITS,
    parameter int KIND_BITS   = bbr_pkg::DEF_KIND_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    input  bbr_pkg::t_op         i_cmd_op,
    input  logic [TAG_BITS-1:0]  i_cmd_tag,
    input  logic [KIND_BITS-1:0] i_cmd_kind,
    output logic                 o_cmd_rd,
    input  logic                 i_res_full,
    output logic                 o_res_wr,
    output logic [TAG_BITS-1:0]  o_res_tag,
    output bbr_pkg::t_res_flags  o_res_flags,
    output logic [KIND_BITS-1:0] o_res_kind
);

    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int NKIND = 1 << KIND_BITS;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EVAL = 3'b100
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_kcnt [NKIND];
    logic [KIND_BITS-1:0] r_mem [STACK_DEPTH];
    logic [KIND_BITS-1:0] r_top;
    bbr_pkg::t_op        r_op;
    logic [TAG_BITS-1:0] r_tag;
    logic [KIND_BITS-1:0] r_kind;

    logic                 stack_full;
    logic [KIND_BITS-1:0] cnt_idx;
    logic [CW-1:0]        kcnt_sel;
    logic [CW-1:0]        cnt_m1;
    logic [AW-1:0]        rd_addr;
    logic                 kcnt_inc, kcnt_dec, mem_we, load;

    assign stack_full = (r_count == CW'(STACK_DEPTH));
    assign cnt_m1     = r_count - CW'(1);
    assign rd_addr    = cnt_m1[AW-1:0];
    // one counter port: popped kind while unwinding, command kind otherwise
    assign cnt_idx    = (r_state == S_EVAL) ? r_top : i_cmd_kind;
    assign kcnt_sel   = r_kcnt[cnt_idx];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        kcnt_inc    = 1'b0;
        kcnt_dec    = 1'b0;
        mem_we      = 1'b0;
        load        = 1'b0;
        o_cmd_rd    = 1'b0;
        o_res_wr    = 1'b0;
        o_res_tag   = '0;
        o_res_flags = '0;
        o_res_kind  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    case (i_cmd_op)
                        bbr_pkg::OP_PASS: begin
                            if (!i_res_full) begin
                                o_cmd_rd         = 1'b1;
                                o_res_wr         = 1'b1;
                                o_res_tag        = i_cmd_tag;
                                o_res_flags.last = 1'b1;
                            end
                        end
                        bbr_pkg::OP_OPEN: begin
                            if (!i_res_full) begin
                                o_cmd_rd             = 1'b1;
                                o_res_wr             = 1'b1;
                                o_res_tag            = i_cmd_tag;
                                o_res_kind           = i_cmd_kind;
                                o_res_flags.overflow = stack_full;
                                o_res_flags.last     = 1'b1;
                                if (!stack_full) begin
                                    mem_we   = 1'b1;
                                    kcnt_inc = 1'b1;
                                    n_count  = r_count + CW'(1);
                                end
                            end
                        end
                        bbr_pkg::OP_CLOSE: begin
                            // no open of this kind anywhere: drop the closer
                            o_cmd_rd = 1'b1;
                            if (kcnt_sel != '0) begin
                                load    = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        bbr_pkg::OP_FLUSH: begin
                            o_cmd_rd = 1'b1;
                            if (r_count != '0) begin
                                load    = 1'b1;
                                n_state = S_READ;
                            end
                        end
                        default: begin
                            o_cmd_rd = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (!i_res_full) begin
                    o_res_wr = 1'b1;
                    kcnt_dec = 1'b1;
                    n_count  = cnt_m1;
                    if (r_op == bbr_pkg::OP_CLOSE && r_top == r_kind) begin
                        o_res_tag        = r_tag;
                        o_res_kind       = r_kind;
                        o_res_flags.last = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_res_kind           = r_top;
                        o_res_flags.inserted = 1'b1;
                        if (r_op == bbr_pkg::OP_FLUSH && r_count == CW'(1)) begin
                            o_res_flags.last = 1'b1;
                            n_state          = S_IDLE;
                        end else begin
                            n_state = S_READ;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            for (int k = 0; k < NKIND; k++) begin
                r_kcnt[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (kcnt_inc) begin
                r_kcnt[cnt_idx] <= kcnt_sel + CW'(1);
            end else if (kcnt_dec) begin
                r_kcnt[cnt_idx] <= kcnt_sel - CW'(1);
            end
        end
    end

    // held command while unwinding
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_op   <= i_cmd_op;
            r_tag  <= i_cmd_tag;
            r_kind <= i_cmd_kind;
        end
    end

    // stack memory, registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_count[AW-1:0]] <= i_cmd_kind;
        end
        r_top <= r_mem[rd_addr];
    end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bracket balance repair block. A short list of
// hand-picked token sequences is followed by random streams that fill and
// drain the open bracket stack. A behavioural stack model or a directed row
// gives each expected output beat, compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top;

    import bbr_pkg::*;

    localparam int STACK_DEPTH = DEF_STACK_DEPTH;
    localparam int TAG_BITS    = DEF_TAG_BITS;
    localparam int KIND_BITS   = DEF_KIND_BITS;
    localparam int N_RANDOM    = 280;

    // input codes not named in the package
    localparam logic REQ_TOKEN = 1'b0;
    localparam logic [SIDE_BITS-1:0] SIDE_NONE  = 2'd0;
    localparam logic [SIDE_BITS-1:0] SIDE_UNDEF = 2'd3;

    // bracket kinds
    localparam logic [KIND_BITS-1:0] K_PAREN  = 2'd0;
    localparam logic [KIND_BITS-1:0] K_SQUARE = 2'd1;
    localparam logic [KIND_BITS-1:0] K_BRACE  = 2'd2;
    localparam logic [KIND_BITS-1:0] K_ANGLE  = 2'd3;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_ONE   = 2'd1,
        CHK_NONE  = 2'd2
    } chk_mode_t;

    // one output beat
    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic                 ins;
        logic [KIND_BITS-1:0] kind;
        logic                 ovf;
        logic                 last;
    } bracket_beat_t;

    // one directed row; repeated rows step tag and kind per beat
    typedef struct packed {
        logic                 req;
        logic [TAG_BITS-1:0]  tag;
        logic [SIDE_BITS-1:0] side;
        logic [KIND_BITS-1:0] kind;
        logic [4:0]           reps;
        chk_mode_t            chk;
        logic [TAG_BITS-1:0]  x_tag;
        logic [KIND_BITS-1:0] x_kind;
        logic                 x_ovf;
    } stim_row_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 i_req_type = 1'b0;
    logic [TAG_BITS-1:0]  i_token_tag = '0;
    logic [SIDE_BITS-1:0] i_bracket_side = '0;
    logic [KIND_BITS-1:0] i_bracket_kind = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [TAG_BITS-1:0]  o_out_tag;
    logic                 o_out_inserted;
    logic [KIND_BITS-1:0] o_out_bracket_kind;
    logic                 o_out_overflow;
    logic                 o_out_last;

    // predicted stack and expected output beats
    logic [KIND_BITS-1:0] open_kinds [STACK_DEPTH];
    int                   open_depth = 0;
    bracket_beat_t        out_beat_q [$];

    int                   n_errors = 0;
    int                   burst_left = 0;
    logic [7:0]           pop_pattern = 8'hFF;
    int                   pop_window = 0;
    stim_row_t            stim [16];

    bracket_balance_repair u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_req_type         (i_req_type),
        .i_token_tag        (i_token_tag),
        .i_bracket_side     (i_bracket_side),
        .i_bracket_kind     (i_bracket_kind),
        .empty              (empty),
        .pop                (pop),
        .o_out_tag          (o_out_tag),
        .o_out_inserted     (o_out_inserted),
        .o_out_bracket_kind (o_out_bracket_kind),
        .o_out_overflow     (o_out_overflow),
        .o_out_last         (o_out_last)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #3_000_000;
        $display("timeout with %0d beats still expected", out_beat_q.size());
        $display("** bracket_balance_repair: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
        n_errors++;
    endtask

    function automatic bracket_beat_t make_beat(input logic [TAG_BITS-1:0] tag,
                                                input logic ins,
                                                input logic [KIND_BITS-1:0] kind,
                                                input logic ovf, input logic last);
        bracket_beat_t b;
        b.tag  = tag;
        b.ins  = ins;
        b.kind = kind;
        b.ovf  = ovf;
        b.last = last;
        return b;
    endfunction

    // append one beat to the expected list
    task automatic expect_beat(input bracket_beat_t b);
        out_beat_q.insert(out_beat_q.size(), b);
    endtask

    // expected beat, only when the item is checked against the predictor
    task automatic note_beat(input bit keep, input bracket_beat_t b);
        if (keep)
            expect_beat(b);
    endtask

    // stack repair prediction for one accepted item
    task automatic repair_stream(input logic req, input logic [TAG_BITS-1:0] tag,
                                 input logic [SIDE_BITS-1:0] side,
                                 input logic [KIND_BITS-1:0] kind, input bit keep);
        int            pos;
        bit            found;
        if (req == REQ_FLUSH) begin
            // close everything, innermost first
            while (open_depth > 0) begin
                open_depth--;
                note_beat(keep, make_beat('0, 1'b1, open_kinds[open_depth], 1'b0,
                                          open_depth == 0));
            end
        end else if (side == SIDE_OPEN) begin
            if (open_depth < STACK_DEPTH) begin
                open_kinds[open_depth] = kind;
                open_depth++;
                note_beat(keep, make_beat(tag, 1'b0, kind, 1'b0, 1'b1));
            end else begin
                note_beat(keep, make_beat(tag, 1'b0, kind, 1'b1, 1'b1));
            end
        end else if (side == SIDE_CLOSE) begin
            // nearest open of the same kind, from the top
            pos = open_depth;
            found = 1'b0;
            while (pos > 0 && !found) begin
                pos--;
                if (open_kinds[pos] == kind)
                    found = 1'b1;
            end
            if (found) begin
                while (open_depth > pos + 1) begin
                    open_depth--;
                    note_beat(keep, make_beat('0, 1'b1, open_kinds[open_depth],
                                              1'b0, 1'b0));
                end
                open_depth = pos;
                note_beat(keep, make_beat(tag, 1'b0, kind, 1'b0, 1'b1));
            end
        end else begin
            // plain token or undefined side code
            note_beat(keep, make_beat(tag, 1'b0, '0, 1'b0, 1'b1));
        end
    endtask

    // present one item, wait for acceptance, then maybe pause the burst
    task automatic send_item(input logic req, input logic [TAG_BITS-1:0] tag,
                             input logic [SIDE_BITS-1:0] side,
                             input logic [KIND_BITS-1:0] kind, input bit keep);
        i_req_type     <= req;
        i_token_tag    <= tag;
        i_bracket_side <= side;
        i_bracket_kind <= kind;
        push           <= 1'b1;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        repair_stream(req, tag, side, kind, keep);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 3) != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 11);
        end
    endtask

    // output side: check each beat taken, stall on a rotating pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (out_beat_q.size() == 0) begin
                    report_mismatch("beat with nothing expected, out_tag",
                                    o_out_tag, '0);
                end else begin
                    bracket_beat_t w;
                    w = out_beat_q.pop_front();
                    if (o_out_tag !== w.tag)
                        report_mismatch("out_tag", o_out_tag, w.tag);
                    if (o_out_inserted !== w.ins)
                        report_mismatch("out_inserted", o_out_inserted, w.ins);
                    if (o_out_bracket_kind !== w.kind)
                        report_mismatch("out_bracket_kind", o_out_bracket_kind, w.kind);
                    if (o_out_overflow !== w.ovf)
                        report_mismatch("out_overflow", o_out_overflow, w.ovf);
                    if (o_out_last !== w.last)
                        report_mismatch("out_last", o_out_last, w.last);
                end
            end
            if (pop_window == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        pop_pattern <= 8'hFF;
                    end
                    3: begin
                        pop_pattern <= 8'h01;
                    end
                    default: begin
                        pop_pattern <= 8'($urandom);
                    end
                endcase
                pop_window <= 50;
            end else begin
                pop_pattern <= {pop_pattern[0], pop_pattern[7:1]};
                pop_window  <= pop_window - 1;
            end
            pop <= pop_pattern[0];
        end
    end

    // stimulus
    initial begin
        int            i;
        int            n;
        int            pick;
        int            seg;
        int            th_flush;
        int            th_plain;
        int            th_open;
        logic          req;
        logic [TAG_BITS-1:0]  tag;
        logic [SIDE_BITS-1:0] side;
        logic [KIND_BITS-1:0] kind;

        // plain tokens at the extremes, undefined side code
        stim[0]  = '{REQ_TOKEN, 32'h0000_0000, SIDE_NONE, K_PAREN, 5'd1,
                     CHK_ONE, 32'h0000_0000, K_PAREN, 1'b0};
        stim[1]  = '{REQ_TOKEN, 32'hFFFF_FFFF, SIDE_NONE, K_ANGLE, 5'd1,
                     CHK_ONE, 32'hFFFF_FFFF, K_PAREN, 1'b0};
        stim[2]  = '{REQ_TOKEN, 32'hA5A5_A5A5, SIDE_UNDEF, K_BRACE, 5'd1,
                     CHK_ONE, 32'hA5A5_A5A5, K_PAREN, 1'b0};
        // flush and closer on an empty stack
        stim[3]  = '{REQ_FLUSH, 32'h0000_DEAD, SIDE_OPEN, K_SQUARE, 5'd1,
                     CHK_NONE, 32'h0, K_PAREN, 1'b0};
        stim[4]  = '{REQ_TOKEN, 32'h0000_1234, SIDE_CLOSE, K_SQUARE, 5'd1,
                     CHK_NONE, 32'h0, K_PAREN, 1'b0};
        // open, open, matching closer on top
        stim[5]  = '{REQ_TOKEN, 32'h0000_0001, SIDE_OPEN, K_PAREN, 5'd1,
                     CHK_ONE, 32'h0000_0001, K_PAREN, 1'b0};
        stim[6]  = '{REQ_TOKEN, 32'h0000_0002, SIDE_OPEN, K_ANGLE, 5'd1,
                     CHK_ONE, 32'h0000_0002, K_ANGLE, 1'b0};
        stim[7]  = '{REQ_TOKEN, 32'h0000_0003, SIDE_CLOSE, K_ANGLE, 5'd1,
                     CHK_ONE, 32'h0000_0003, K_ANGLE, 1'b0};
        // unmatched closer over a live stack, then a deep match
        stim[8]  = '{REQ_TOKEN, 32'h0000_0004, SIDE_OPEN, K_SQUARE, 5'd1,
                     CHK_MODEL, 32'h0, K_PAREN, 1'b0};
        stim[9]  = '{REQ_TOKEN, 32'h0000_0005, SIDE_OPEN, K_BRACE, 5'd1,
                     CHK_MODEL, 32'h0, K_PAREN, 1'b0};
        stim[10] = '{REQ_TOKEN, 32'h0000_0006, SIDE_CLOSE, K_ANGLE, 5'd1,
                     CHK_NONE, 32'h0, K_PAREN, 1'b0};
        stim[11] = '{REQ_TOKEN, 32'h0000_0007, SIDE_CLOSE, K_PAREN, 5'd1,
                     CHK_MODEL, 32'h0, K_PAREN, 1'b0};
        // fill the stack, overflow, deep repair, flush the rest
        stim[12] = '{REQ_TOKEN, 32'h0000_0100, SIDE_OPEN, K_PAREN, 5'd16,
                     CHK_MODEL, 32'h0, K_PAREN, 1'b0};
        stim[13] = '{REQ_TOKEN, 32'hFFFF_0000, SIDE_OPEN, K_BRACE, 5'd1,
                     CHK_ONE, 32'hFFFF_0000, K_BRACE, 1'b1};
        stim[14] = '{REQ_TOKEN, 32'h8000_0008, SIDE_CLOSE, K_PAREN, 5'd1,
                     CHK_MODEL, 32'h0, K_PAREN, 1'b0};
        stim[15] = '{REQ_FLUSH, 32'h0000_0000, SIDE_NONE, K_PAREN, 5'd1,
                     CHK_MODEL, 32'h0, K_PAREN, 1'b0};

        // reset
        repeat (3)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        burst_left = $urandom_range(0, 11);

        // directed rows
        foreach (stim[r]) begin
            for (i = 0; i < stim[r].reps; i++) begin
                if (stim[r].chk == CHK_ONE)
                    expect_beat(make_beat(stim[r].x_tag, 1'b0, stim[r].x_kind,
                                          stim[r].x_ovf, 1'b1));
                send_item(stim[r].req, stim[r].tag + i, stim[r].side,
                          stim[r].kind + i[KIND_BITS-1:0], stim[r].chk == CHK_MODEL);
            end
        end

        // random streams in segments that lean to fill, balance or drain
        seg = 0;
        for (n = 0; n < N_RANDOM; n++) begin
            if (n % 40 == 0)
                seg = $urandom_range(0, 2);
            case (seg)
                0: begin
                    th_flush = 5;  th_plain = 20; th_open = 60;
                end
                1: begin
                    th_flush = 1;  th_plain = 8;  th_open = 78;
                end
                default: begin
                    th_flush = 10; th_plain = 25; th_open = 50;
                end
            endcase
            pick = $urandom_range(0, 99);
            req  = REQ_TOKEN;
            tag  = TAG_BITS'($urandom);
            kind = KIND_BITS'($urandom_range(0, 3));
            if (pick < th_flush) begin
                req  = REQ_FLUSH;
                side = SIDE_BITS'($urandom_range(0, 3));
            end else if (pick < th_plain) begin
                side = ($urandom_range(0, 3) == 0) ? SIDE_UNDEF : SIDE_NONE;
            end else if (pick < th_open) begin
                side = SIDE_OPEN;
            end else begin
                side = SIDE_CLOSE;
                // mostly close something that is open, top or deeper
                if (open_depth > 0 && $urandom_range(0, 9) < 7) begin
                    if ($urandom_range(0, 1) == 1)
                        kind = open_kinds[open_depth - 1];
                    else
                        kind = open_kinds[$urandom_range(0, open_depth - 1)];
                end
            end
            send_item(req, tag, side, kind, 1'b1);
        end
        push <= 1'b0;

        // drain, then allow for late extra beats
        while (out_beat_q.size() != 0)
            @(posedge i_clk);
        repeat (64)
            @(posedge i_clk);
        if (n_errors == 0 && out_beat_q.size() == 0) begin
            $display("** bracket_balance_repair: PASSED **");
        end else begin
            $display("** bracket_balance_repair: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/bbr_pkg.sv
hw/rtl/bbr_fifo.sv
hw/rtl/bbr_front.sv
hw/rtl/bbr_back.sv
hw/rtl/bracket_balance_repair.sv
sim/tb_top.sv
